// ===== hdl/text_console_formatter_defines.svh =====
// ----------------------------------------------------------------------------
// text console formatter assertion macros
// shared checks for clocked properties on the clock and reset of the block
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_FORMATTER_DEFINES_SVH
`define TEXT_CONSOLE_FORMATTER_DEFINES_SVH

// checked outside reset
`define TCF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define TCF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/tcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcf_pkg
// types and constants shared by the text console formatter modules
// ----------------------------------------------------------------------------
`default_nettype none

package tcf_pkg;

   typedef enum logic [1:0] {
      JOB_CHAR,
      JOB_HEX,
      JOB_NULL
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   chr;
      logic [63:0]  arg;
   } job_type;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_COLOR    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SERIAL_ENABLE = 1'd1;

   localparam logic [15:0] TEXT_COLOR_RESET = 16'h0700;

   localparam logic [7:0] CH_PERCENT  = 8'h25;
   localparam logic [7:0] CH_LOWER_X  = 8'h78;
   localparam logic [7:0] CH_LOWER_S  = 8'h73;
   localparam logic [7:0] CH_QUESTION = 8'h3F;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NEWLINE  = 8'h0A;

   localparam int CNT_W = 5;
   localparam logic [CNT_W-1:0] HEX_LAST  = 5'd17;
   localparam logic [CNT_W-1:0] NULL_LAST = 5'd5;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      logic [7:0] code;
      begin
         if (nibble < 4'd10) begin
            code = 8'h30 + {4'd0, nibble};
         end else begin
            code = 8'h37 + {4'd0, nibble};
         end
         return code;
      end
   endfunction

   function automatic logic [7:0] null_char(input logic [2:0] idx);
      logic [7:0] code;
      begin
         case (idx)
            3'd0: code = 8'h28;
            3'd1: code = 8'h6E;
            3'd2: code = 8'h75;
            3'd3: code = 8'h6C;
            3'd4: code = 8'h6C;
            3'd5: code = 8'h29;
            default: code = 8'h00;
         endcase
         return code;
      end
   endfunction

endpackage

`default_nettype wire

// ===== hdl/tcf_front.sv =====
// ----------------------------------------------------------------------------
// tcf_front
// accepts input beats, tracks a pending percent and turns each item that
// prints into a print job for the queue
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_front
   import tcf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // format_char, arg_value
   input  wire logic                   req_tuser,   // mode
   input  wire logic                   q_full,
   output logic                        q_push,
   output job_type                     q_job
);

   logic       pending_ff;
   logic       pending_in;
   logic       has_job;
   logic [7:0] chr;
   logic [63:0] arg;
   logic       accept;

   assign chr        = req_tdata[7:0];
   assign arg        = req_tdata[71:8];
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept && has_job;

   always_comb begin
      has_job      = 1'b1;
      pending_in   = pending_ff;
      q_job.kind   = JOB_CHAR;
      q_job.chr    = chr;
      q_job.arg    = arg;
      if (req_tuser) begin
         has_job = 1'b1;
      end else if (!pending_ff) begin
         if (chr == CH_PERCENT) begin
            has_job    = 1'b0;
            pending_in = accept ? 1'b1 : pending_ff;
         end
      end else begin
         pending_in = accept ? 1'b0 : pending_ff;
         case (chr)
            CH_LOWER_X: begin
               q_job.kind = JOB_HEX;
            end
            CH_PERCENT: begin
               q_job.chr = CH_PERCENT;
            end
            CH_LOWER_S: begin
               q_job.kind = JOB_NULL;
               has_job    = (arg == 64'd0);
            end
            default: begin
               q_job.chr = CH_QUESTION;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tcf_queue.sv =====
// ----------------------------------------------------------------------------
// tcf_queue
// small job fifo between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_queue
   import tcf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output logic         empty,
   output job_type      head_job
);

   job_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;
   logic [QPTR_W:0]     count_in;

   assign full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tcf_back.sv =====
// ----------------------------------------------------------------------------
// tcf_back
// runs print jobs one character per cycle while the result channel is not
// stalled, keeps the cursor and drives the registered result channel
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_back
   import tcf_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   job_valid,
   input  wire job_type                job,
   output logic                        job_pop,
   input  wire logic [15:0]            text_color,
   input  wire logic                   serial_enable,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,  // cell_index, cell_data, serial_char
   output logic [RSP_TUSER_W-1:0]      rsp_tuser,  // cell_write, serial_valid
   output logic                        rsp_tlast
);

   localparam int COL_W  = $clog2(COLUMNS + 1);
   localparam int ROW_W  = $clog2(ROWS + 1);
   localparam int BASE_W = $clog2(COLUMNS * ROWS + 1);
   localparam int SUM_W  = (BASE_W > 11) ? BASE_W : 11;

   logic               active_ff, active_in;
   job_kind_type       kind_ff, kind_in;
   logic [7:0]         chr_ff, chr_in;
   logic [63:0]        arg_ff, arg_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [BASE_W-1:0]  base_ff, base_in;

   logic               out_valid_ff, out_valid_in;
   logic               out_write_ff, out_write_in;
   logic [10:0]        out_index_ff, out_index_in;
   logic [15:0]        out_data_ff, out_data_in;
   logic               out_sv_ff, out_sv_in;
   logic [7:0]         out_sc_ff, out_sc_in;
   logic               out_last_ff, out_last_in;

   logic               advance;
   logic               emit;
   logic [7:0]         cur_ch;
   logic               is_last;
   logic               is_newline;
   logic [COL_W-1:0]   col_plus;
   logic               wrap;
   logic [SUM_W-1:0]   index_sum;

   assign advance    = !out_valid_ff || rsp_tready;
   assign emit       = active_ff && advance;
   assign job_pop    = job_valid && (!active_ff || (emit && is_last));
   assign is_newline = (cur_ch == CH_NEWLINE);
   assign col_plus   = col_ff + 1'b1;
   assign wrap       = is_newline || (col_plus == COL_W'(COLUMNS));
   assign index_sum  = SUM_W'(base_ff) + SUM_W'(col_ff);

   always_comb begin
      cur_ch  = chr_ff;
      is_last = 1'b1;
      case (kind_ff)
         JOB_CHAR: begin
            cur_ch  = chr_ff;
            is_last = 1'b1;
         end
         JOB_HEX: begin
            if (cnt_ff == 5'd0) begin
               cur_ch = CH_ZERO;
            end else if (cnt_ff == 5'd1) begin
               cur_ch = CH_LOWER_X;
            end else begin
               cur_ch = hex_char(arg_ff[63:60]);
            end
            is_last = (cnt_ff == HEX_LAST);
         end
         JOB_NULL: begin
            cur_ch  = null_char(cnt_ff[2:0]);
            is_last = (cnt_ff == NULL_LAST);
         end
         default: begin
            cur_ch  = 8'd0;
            is_last = 1'b1;
         end
      endcase
   end

   // job sequencing
   always_comb begin
      active_in = active_ff;
      kind_in   = kind_ff;
      chr_in    = chr_ff;
      arg_in    = arg_ff;
      cnt_in    = cnt_ff;
      if (job_pop) begin
         active_in = 1'b1;
         kind_in   = job.kind;
         chr_in    = job.chr;
         arg_in    = job.arg;
         cnt_in    = '0;
      end else if (emit) begin
         if (is_last) begin
            active_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            if (kind_ff == JOB_HEX && cnt_ff > 5'd1) begin
               arg_in = {arg_ff[59:0], 4'd0};
            end
         end
      end
   end

   // cursor
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      base_in = base_ff;
      if (emit) begin
         if (wrap) begin
            col_in = '0;
            if (row_ff != ROW_W'(ROWS - 1)) begin
               row_in  = row_ff + 1'b1;
               base_in = base_ff + BASE_W'(COLUMNS);
            end
         end else begin
            col_in = col_plus;
         end
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_write_in = out_write_ff;
      out_index_in = out_index_ff;
      out_data_in  = out_data_ff;
      out_sv_in    = out_sv_ff;
      out_sc_in    = out_sc_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_write_in = !is_newline;
         out_index_in = is_newline ? 11'd0 : index_sum[10:0];
         out_data_in  = is_newline ? 16'd0 : ({8'd0, cur_ch} | text_color);
         out_sv_in    = serial_enable;
         out_sc_in    = serial_enable ? cur_ch : 8'd0;
         out_last_in  = is_last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         base_ff      <= base_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      chr_ff       <= chr_in;
      arg_ff       <= arg_in;
      cnt_ff       <= cnt_in;
      out_write_ff <= out_write_in;
      out_index_ff <= out_index_in;
      out_data_ff  <= out_data_in;
      out_sv_ff    <= out_sv_in;
      out_sc_ff    <= out_sc_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_sc_ff, out_data_ff, out_index_ff};
   assign rsp_tuser  = {out_sv_ff, out_write_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// ===== hdl/text_console_formatter.sv =====
// ----------------------------------------------------------------------------
// text_console_formatter
// Text console with printf-style conversions. The front accepts one item per
// cycle while its four-entry job queue has room; the back sends one result
// beat per cycle, unless the result channel stalls, through a single output
// register. A %x item yields 18 beats, a %s with a zero argument 6, a '%'
// that opens a conversion or a %s with a nonzero argument none, every other
// item one. Sustained rate is therefore set by the back's one character per
// cycle. Configuration writes take effect on the next cycle and are meant
// for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_formatter_defines.svh"

module text_console_formatter
   import tcf_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // format_char, arg_value
   input  wire logic                   req_tuser,  // mode
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,  // cell_index, cell_data, serial_char
   output logic [RSP_TUSER_W-1:0]      rsp_tuser,  // cell_write, serial_valid
   output logic                        rsp_tlast
);

   logic [15:0] text_color_ff;
   logic        serial_enable_ff;

   logic        q_push;
   logic        q_full;
   logic        q_pop;
   logic        q_empty;
   job_type     q_in_job;
   job_type     q_head_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff    <= TEXT_COLOR_RESET;
         serial_enable_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TEXT_COLOR:    text_color_ff    <= csr_wdata;
            CSR_SERIAL_ENABLE: serial_enable_ff <= csr_wdata[0];
            default: begin
               text_color_ff <= text_color_ff;
            end
         endcase
      end
   end

   tcf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (q_in_job)
   );

   tcf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_in_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_job (q_head_job)
   );

   tcf_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (!q_empty),
      .job           (q_head_job),
      .job_pop       (q_pop),
      .text_color    (text_color_ff),
      .serial_enable (serial_enable_ff),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast)
   );

   `TCF_ASSERT(a_queue_no_overflow, !(q_push && q_full), "job pushed into full queue")
   `TCF_ASSERT(a_queue_no_underflow, !(q_pop && q_empty), "job popped from empty queue")
   `TCF_ASSERT_ALWAYS(a_idle_after_reset, $past(reset) |-> !rsp_tvalid, "result valid after reset")

endmodule

`default_nettype wire
